### src/rrf_pkg.sv
// Shared widths, parameter defaults and controller/datapath signal groups for the filter.
package rrf_pkg;

  localparam int STAMP_W = 32;
  localparam int SENDER_W = 32;
  localparam int COUNT_W = 6;
  localparam int COUNT_FIELD_MAX = 63;

  localparam int TABLE_SLOTS_DEFAULT = 4;
  localparam int MAX_BATCH_DEFAULT = 32;

  typedef struct packed {
    logic load_in;
    logic load_match;
    logic decide;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

endpackage

### src/rrf_in_if.sv
// Request channel that carries one decoded reading.
interface rrf_in_if;
  logic                         valid;
  logic                         ready;
  logic [rrf_pkg::SENDER_W-1:0] sender_id;
  logic [rrf_pkg::STAMP_W-1:0]  raw_stamp;
  logic                         stamp_is_age;
  logic [rrf_pkg::STAMP_W-1:0]  now_epoch;
  logic                         may_repeat;
  logic                         last_of_batch;

  modport source (
    output valid, sender_id, raw_stamp, stamp_is_age, now_epoch, may_repeat, last_of_batch,
    input  ready
  );
  modport sink (
    input  valid, sender_id, raw_stamp, stamp_is_age, now_epoch, may_repeat, last_of_batch,
    output ready
  );
endinterface

### src/rrf_out_if.sv
// Result channel that carries the verdict for one reading.
interface rrf_out_if;
  logic                        valid;
  logic                        ready;
  logic                        deliver;
  logic [rrf_pkg::STAMP_W-1:0] reading_time;
  logic [rrf_pkg::COUNT_W-1:0] delivered_count;
  logic                        batch_done;

  modport source (
    output valid, deliver, reading_time, delivered_count, batch_done,
    input  ready
  );
  modport sink (
    input  valid, deliver, reading_time, delivered_count, batch_done,
    output ready
  );
endinterface

### src/rrf_ctrl.sv
// Sequencing state machine for the repeat reading filter.
module rrf_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  output logic             out_valid,
  input  logic             out_ready,
  input  rrf_pkg::status_t status,
  output rrf_pkg::cmd_t    cmd
);

  typedef enum logic [1:0] {
    S_IDLE,
    S_MATCH,
    S_DECIDE,
    S_COMMIT
  } state_t;

  state_t state;
  logic   out_free;

  assign out_free = !out_valid || out_ready;
  assign in_ready = (state == S_IDLE);

  always_comb begin
    cmd            = '0;
    cmd.load_in    = (state == S_IDLE) && in_valid;
    cmd.load_match = (state == S_MATCH);
    cmd.decide     = (state == S_DECIDE) && out_free;
    cmd.commit     = (state == S_COMMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.decide) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_MATCH;
          end
        end
        S_MATCH: begin
          state <= S_DECIDE;
        end
        S_DECIDE: begin
          if (out_free) begin
            state <= status.last ? S_COMMIT : S_IDLE;
          end
        end
        S_COMMIT: begin
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

### src/rrf_datapath.sv
// Dating, sender table lookup, batch accumulators and result register.
module rrf_datapath #(
  parameter int TABLE_SLOTS = rrf_pkg::TABLE_SLOTS_DEFAULT,
  parameter int MAX_BATCH   = rrf_pkg::MAX_BATCH_DEFAULT
) (
  input  logic                         clk,
  input  logic                         rst,
  input  rrf_pkg::cmd_t                cmd,
  output rrf_pkg::status_t             status,
  input  logic [rrf_pkg::SENDER_W-1:0] sender_id,
  input  logic [rrf_pkg::STAMP_W-1:0]  raw_stamp,
  input  logic                         stamp_is_age,
  input  logic [rrf_pkg::STAMP_W-1:0]  now_epoch,
  input  logic                         may_repeat,
  input  logic                         last_of_batch,
  output logic                         deliver,
  output logic [rrf_pkg::STAMP_W-1:0]  reading_time,
  output logic [rrf_pkg::COUNT_W-1:0]  delivered_count,
  output logic                         batch_done
);

  localparam int SLOT_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
  localparam int COUNT_CAP_I = (MAX_BATCH < rrf_pkg::COUNT_FIELD_MAX) ?
                               MAX_BATCH : rrf_pkg::COUNT_FIELD_MAX;
  localparam logic [rrf_pkg::COUNT_W-1:0] COUNT_CAP = rrf_pkg::COUNT_W'(COUNT_CAP_I);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_SLOTS - 1);

  logic [rrf_pkg::SENDER_W-1:0] slot_sender [TABLE_SLOTS];
  logic [rrf_pkg::STAMP_W-1:0]  slot_newest [TABLE_SLOTS];
  logic [SLOT_W-1:0]            replace_pointer;
  logic [rrf_pkg::STAMP_W-1:0]  batch_newest;
  logic [rrf_pkg::COUNT_W-1:0]  batch_delivered;
  logic [rrf_pkg::STAMP_W-1:0]  commit_stamp;

  logic [rrf_pkg::SENDER_W-1:0] sender;
  logic [rrf_pkg::STAMP_W-1:0]  stamp;
  logic                         check_repeat;
  logic                         last;
  logic [TABLE_SLOTS-1:0]       eq_vec;
  logic [TABLE_SLOTS-1:0]       le_vec;

  logic [rrf_pkg::STAMP_W-1:0]  stamp_next;
  logic [TABLE_SLOTS-1:0]       first_vec;
  logic                         pass;
  logic [rrf_pkg::STAMP_W-1:0]  batch_newest_next;
  logic [rrf_pkg::COUNT_W-1:0]  batch_delivered_next;

  assign status.last = last;

  always_comb begin
    if (stamp_is_age) begin
      stamp_next = (raw_stamp < now_epoch) ? (now_epoch - raw_stamp) : '0;
    end else begin
      stamp_next = raw_stamp;
    end
  end

  // The lowest-numbered slot holding the sender is the only one that counts.
  assign first_vec = eq_vec & (~eq_vec + TABLE_SLOTS'(1));
  assign pass = !(check_repeat && (|(first_vec & le_vec)));

  always_comb begin
    batch_newest_next    = batch_newest;
    batch_delivered_next = batch_delivered;
    if (pass) begin
      if (stamp > batch_newest) begin
        batch_newest_next = stamp;
      end
      if (batch_delivered < COUNT_CAP) begin
        batch_delivered_next = batch_delivered + rrf_pkg::COUNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      sender       <= sender_id;
      stamp        <= stamp_next;
      check_repeat <= may_repeat && (stamp_next != '0);
      last         <= last_of_batch;
    end
    if (cmd.load_match) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        eq_vec[i] <= (slot_sender[i] == sender);
        le_vec[i] <= (stamp <= slot_newest[i]);
      end
    end
    if (cmd.decide) begin
      deliver         <= pass;
      reading_time    <= stamp;
      delivered_count <= batch_delivered_next;
      batch_done      <= last;
      commit_stamp    <= batch_newest_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < TABLE_SLOTS; i++) begin
        slot_sender[i] <= '0;
        slot_newest[i] <= '0;
      end
      replace_pointer <= '0;
      batch_newest    <= '0;
      batch_delivered <= '0;
    end else begin
      if (cmd.decide) begin
        if (last) begin
          batch_newest    <= '0;
          batch_delivered <= '0;
        end else begin
          batch_newest    <= batch_newest_next;
          batch_delivered <= batch_delivered_next;
        end
      end
      if (cmd.commit && (commit_stamp != '0)) begin
        if (|eq_vec) begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (first_vec[i] && (commit_stamp > slot_newest[i])) begin
              slot_newest[i] <= commit_stamp;
            end
          end
        end else begin
          for (int i = 0; i < TABLE_SLOTS; i++) begin
            if (replace_pointer == SLOT_W'(i)) begin
              slot_sender[i] <= sender;
              slot_newest[i] <= commit_stamp;
            end
          end
          replace_pointer <= (replace_pointer == LAST_SLOT) ? '0 :
                             replace_pointer + SLOT_W'(1);
        end
      end
    end
  end

endmodule

### src/repeat_reading_filter_top.sv
// Top level of the repeat reading filter: channel interfaces, controller and datapath.
//
// The reading channel takes one decoded reading per request: sender, stamp,
// age flag, receiver time, repeat flag and end-of-batch mark. The result
// channel returns one request per reading with the deliver verdict, the dated
// time, the running delivered count and an echo of the end-of-batch mark.
// Readings are handled one at a time. A reading is taken in the idle state,
// the sender table is compared in the next cycle, and the verdict is written
// to the result register in the decide state once that register is free. A
// reading that closes a batch then writes the sender table in the commit
// state. Each reading thus passes the idle, match and decide states, and the
// commit state as well at the end of a batch.
// Reset clears the sender table, the round-robin pointer and the batch
// accumulators. If the receiver stalls, the result holds in its register and
// the next reading may already be taken and compared; it waits for the result
// register to empty before its own verdict is written.
module repeat_reading_filter_top #(
  parameter int TABLE_SLOTS = rrf_pkg::TABLE_SLOTS_DEFAULT,
  parameter int MAX_BATCH   = rrf_pkg::MAX_BATCH_DEFAULT
) (
  input logic     clk,
  input logic     rst,
  rrf_in_if.sink  reading,
  rrf_out_if.source result
);

  rrf_pkg::cmd_t    cmd;
  rrf_pkg::status_t status;

  rrf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (reading.valid),
    .in_ready  (reading.ready),
    .out_valid (result.valid),
    .out_ready (result.ready),
    .status    (status),
    .cmd       (cmd)
  );

  rrf_datapath #(
    .TABLE_SLOTS (TABLE_SLOTS),
    .MAX_BATCH   (MAX_BATCH)
  ) u_datapath (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .status          (status),
    .sender_id       (reading.sender_id),
    .raw_stamp       (reading.raw_stamp),
    .stamp_is_age    (reading.stamp_is_age),
    .now_epoch       (reading.now_epoch),
    .may_repeat      (reading.may_repeat),
    .last_of_batch   (reading.last_of_batch),
    .deliver         (result.deliver),
    .reading_time    (result.reading_time),
    .delivered_count (result.delivered_count),
    .batch_done      (result.batch_done)
  );

endmodule

### src/rrf_checker.sv
// Port-level checks for the repeat reading filter and their binding to the top level.
module rrf_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic                        deliver,
  input logic [rrf_pkg::STAMP_W-1:0] reading_time,
  input logic [rrf_pkg::COUNT_W-1:0] delivered_count,
  input logic                        batch_done
);

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result request dropped while stalled");

  a_out_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(reading_time) && $stable(deliver) &&
      $stable(delivered_count) && $stable(batch_done))
    else $error("result payload changed while stalled");

  a_zero_never_dropped: assert property (@(posedge clk) disable iff (rst)
    out_valid && !deliver |-> reading_time != '0)
    else $error("reading dated zero was dropped as a repeat");

  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && deliver |-> delivered_count != '0)
    else $error("delivered reading left the count at zero");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second reading taken while one is in flight");

endmodule

bind repeat_reading_filter_top rrf_checker u_rrf_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (reading.valid),
  .in_ready        (reading.ready),
  .out_valid       (result.valid),
  .out_ready       (result.ready),
  .deliver         (result.deliver),
  .reading_time    (result.reading_time),
  .delivered_count (result.delivered_count),
  .batch_done      (result.batch_done)
);
